[design/divreg_pkg.sv]
// ----------------------------------------------------------------------------
// divreg_pkg
// Shared types and constants for the divider register offset block.
// ----------------------------------------------------------------------------
package divreg_pkg;

  localparam int unsigned CountBits = 16;
  localparam int unsigned StepBits  = 4;
  localparam int unsigned DivBits   = 8;
  localparam int unsigned ModeBits  = 2;

  // operation codes carried in tuser
  localparam logic [ModeBits-1:0] ModeRead  = 2'd0;
  localparam logic [ModeBits-1:0] ModeWrite = 2'd1;
  localparam logic [ModeBits-1:0] ModeQuery = 2'd2;

  // tdata widths: input packed and padded to whole bytes
  localparam int unsigned InDataBits  = 24;
  localparam int unsigned OutDataBits = DivBits + 4 * CountBits;

  typedef struct packed {
    logic [StepBits-1:0]  counter_step_log2;
    logic                 double_speed;
    logic [CountBits-1:0] clock_cycle;
    logic [ModeBits-1:0]  mode;
  } item_t;

  typedef struct packed {
    logic [CountBits-1:0] offset_now;
    logic [CountBits-1:0] clock_adjust;
    logic [CountBits-1:0] new_next_increment;
    logic [CountBits-1:0] old_next_increment;
    logic [DivBits-1:0]   div_value;
  } result_t;

  typedef struct packed {
    logic [CountBits-1:0] divider_offset;
    logic [CountBits-1:0] previous_offset;
  } offsets_t;

endpackage

[design/divreg_calc.sv]
// ----------------------------------------------------------------------------
// divreg_calc
// Datapath for one item: divider read, offset update and reset-details query.
// ----------------------------------------------------------------------------
module divreg_calc (
  input  divreg_pkg::item_t    item_i,
  input  divreg_pkg::offsets_t offs_i,
  output divreg_pkg::offsets_t offs_o,
  output divreg_pkg::result_t  result_o
);
  import divreg_pkg::*;

  logic [CountBits-1:0] cur_cnt;
  logic [CountBits-1:0] old_cnt;
  logic [CountBits-1:0] step;
  logic [CountBits-1:0] low_mask;
  logic [CountBits-1:0] trig;
  logic [CountBits-1:0] old_next;
  logic [CountBits-1:0] new_next;
  logic                 falls;

  assign cur_cnt  = item_i.clock_cycle + offs_i.divider_offset;
  assign old_cnt  = item_i.clock_cycle + offs_i.previous_offset;
  assign step     = CountBits'(1) << item_i.counter_step_log2;
  assign low_mask = step - CountBits'(1);
  assign trig     = step >> 1;
  assign old_next = step - (old_cnt & low_mask);
  assign new_next = step - (cur_cnt & low_mask);
  // trigger bit set under old alignment and clear under new one
  assign falls    = ((old_cnt & trig) != '0) && ((cur_cnt & trig) == '0);

  always_comb begin
    offs_o   = offs_i;
    result_o = '0;
    case (item_i.mode)
      ModeRead: begin
        result_o.div_value = item_i.double_speed ? cur_cnt[14:7] : cur_cnt[15:8];
      end
      ModeWrite: begin
        offs_o.previous_offset = offs_i.divider_offset;
        offs_o.divider_offset  = CountBits'(0) - item_i.clock_cycle;
      end
      ModeQuery: begin
        result_o.old_next_increment = old_next;
        result_o.new_next_increment = new_next;
        result_o.clock_adjust       = falls ? (CountBits'(0) - old_next)
                                            : (new_next - old_next);
      end
      default: begin
        result_o = '0;
      end
    endcase
    result_o.offset_now = offs_o.divider_offset;
  end

endmodule

[design/divider_register_offset.sv]
// ----------------------------------------------------------------------------
// divider_register_offset
// Divider register kept as an offset on a free-running cycle count.
// ----------------------------------------------------------------------------
// channel  | dir | fields (tdata/tuser, lowest bit first)
// s_axis   | in  | tuser: mode; tdata: clock_cycle, double_speed,
//          |     |   counter_step_log2, zero pad to 24 bits
// m_axis   | out | tdata: div_value, old_next_increment, new_next_increment,
//          |     |   clock_adjust, offset_now
//
// One beat per cycle sustained unless the output stalls; a beat passes the
// input register, then the result register. The offset registers update
// as an item moves into the result register, so items see them in arrival
// order. Reset clears both offsets and the valid flags.
// A stalled output holds the result; the input register still drains into
// it as soon as it is taken.
// ----------------------------------------------------------------------------
module divider_register_offset (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // mode
  input  logic [divreg_pkg::ModeBits-1:0]     s_axis_tuser,
  // clock_cycle, double_speed, counter_step_log2, pad
  input  logic [divreg_pkg::InDataBits-1:0]   s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // div_value, old_next_increment, new_next_increment, clock_adjust, offset_now
  output logic [divreg_pkg::OutDataBits-1:0]  m_axis_tdata
);
  import divreg_pkg::*;

  logic     in_valid_q;
  item_t    in_item_q;
  logic     out_valid_q;
  result_t  out_res_q;
  offsets_t offs_q;
  offsets_t offs_d;
  result_t  res_d;
  logic     advance;
  item_t    in_item_d;

  assign in_item_d.mode              = s_axis_tuser;
  assign in_item_d.clock_cycle       = s_axis_tdata[CountBits-1:0];
  assign in_item_d.double_speed      = s_axis_tdata[CountBits];
  assign in_item_d.counter_step_log2 = s_axis_tdata[CountBits+StepBits:CountBits+1];

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  divreg_calc u_calc (
    .item_i   (in_item_q),
    .offs_i   (offs_q),
    .offs_o   (offs_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      offs_q      <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        offs_q      <= offs_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q <= in_item_d;
    end
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_res_q;

endmodule

[design/divreg_checker.sv]
// ----------------------------------------------------------------------------
// divreg_checker
// Port-level checks for divider_register_offset, bound to the top level.
// ----------------------------------------------------------------------------
module divreg_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [divreg_pkg::OutDataBits-1:0]  m_axis_tdata
);
  import divreg_pkg::*;

  result_t res;
  assign res = m_axis_tdata;

  // input side stalls only behind a full, blocked output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // a query result carries a consistent adjustment
  a_adjust: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.old_next_increment != '0) |->
      (res.clock_adjust == res.new_next_increment - res.old_next_increment ||
       res.clock_adjust == CountBits'(0) - res.old_next_increment))
    else $error("clock_adjust inconsistent with next increments");

  // query fields and divider byte never show together
  a_one_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.div_value != '0) |->
      (res.old_next_increment == '0 && res.new_next_increment == '0 &&
       res.clock_adjust == '0))
    else $error("read and query fields both set");

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output beat changed");

endmodule

bind divider_register_offset divreg_checker u_divreg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/divider_register_offset_tb.sv]
// ----------------------------------------------------------------------------
// divider_register_offset_tb
// Drives read, write, query and unused-mode beats into the divider offset
// block and checks every result beat against an in-order prediction of the
// two offset registers. Both stream sides get random idle bursts except in
// the closing back-to-back phase.
// ----------------------------------------------------------------------------
module divider_register_offset_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import divreg_pkg::*;

  localparam logic [ModeBits-1:0] ModeUnused = 2'd3;
  localparam int unsigned DrainCycles = 8;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [ModeBits-1:0]    s_axis_tuser;
  logic [InDataBits-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OutDataBits-1:0] m_axis_tdata;

  bit      gaps_on = 1'b1;
  int      err_count = 0;
  result_t expected_div_results[$];

  // predicted copy of the block's offset registers
  logic [CountBits-1:0] cur_offset;
  logic [CountBits-1:0] last_offset;

  divider_register_offset i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // next divider result, updating the predicted offsets
  function automatic result_t predict_div_access(input logic [ModeBits-1:0] mode,
                                                 input logic [CountBits-1:0] cyc,
                                                 input logic dbl,
                                                 input logic [StepBits-1:0] step_log2);
    result_t              res;
    logic [CountBits-1:0] aligned_new;
    logic [CountBits-1:0] aligned_old;
    logic [CountBits-1:0] step;
    logic [CountBits-1:0] low_mask;
    logic [CountBits-1:0] trig;
    res = '0;
    aligned_new = cyc + cur_offset;
    aligned_old = cyc + last_offset;
    case (mode)
      ModeRead: begin
        res.div_value = dbl ? aligned_new[14:7] : aligned_new[15:8];
      end
      ModeWrite: begin
        last_offset = cur_offset;
        cur_offset  = 16'd0 - cyc;
      end
      ModeQuery: begin
        step     = 16'd1 << step_log2;
        low_mask = step - 16'd1;
        trig     = step >> 1;
        res.old_next_increment = step - (aligned_old & low_mask);
        res.new_next_increment = step - (aligned_new & low_mask);
        // trigger bit drops across the reset: counter loses the old distance
        if (((aligned_old & trig) != '0) && ((aligned_new & trig) == '0))
          res.clock_adjust = 16'd0 - res.old_next_increment;
        else
          res.clock_adjust = res.new_next_increment - res.old_next_increment;
      end
      default: ;
    endcase
    res.offset_now = cur_offset;
    return res;
  endfunction

  task automatic send_div_access(input logic [ModeBits-1:0] mode,
                                 input logic [CountBits-1:0] cyc,
                                 input logic dbl,
                                 input logic [StepBits-1:0] step_log2);
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {3'b000, step_log2, dbl, cyc};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_div_results.push_back(predict_div_access(mode, cyc, dbl, step_log2));
  endtask

  task automatic test_reads_after_reset();
    send_div_access(ModeRead, 16'h0000, 1'b0, 4'd1);
    send_div_access(ModeRead, 16'hFFFF, 1'b0, 4'd1);
    send_div_access(ModeRead, 16'hFFFF, 1'b1, 4'd1);
    send_div_access(ModeRead, 16'h8080, 1'b1, 4'd1);
  endtask

  task automatic test_divider_writes();
    send_div_access(ModeWrite, 16'h0000, 1'b0, 4'd1);  // offset stays zero
    send_div_access(ModeWrite, 16'h1234, 1'b0, 4'd1);
    send_div_access(ModeRead,  16'h1334, 1'b0, 4'd1);
    send_div_access(ModeWrite, 16'hFFFF, 1'b1, 4'd15);
    send_div_access(ModeRead,  16'hFFFF, 1'b1, 4'd15);
    send_div_access(ModeRead,  16'h00FF, 1'b1, 4'd15);
  endtask

  task automatic test_reset_queries();
    send_div_access(ModeQuery,  16'h0000, 1'b0, 4'd0);  // unit step
    send_div_access(ModeQuery,  16'hFFFF, 1'b1, 4'd15);
    send_div_access(ModeQuery,  16'hFFFF, 1'b0, 4'd1);
    send_div_access(ModeWrite,  16'h0000, 1'b0, 4'd4);
    send_div_access(ModeWrite,  16'h0014, 1'b0, 4'd4);
    send_div_access(ModeQuery,  16'h0018, 1'b0, 4'd4);  // trigger bit falls
    send_div_access(ModeQuery,  16'h8000, 1'b0, 4'd15);
    send_div_access(ModeQuery,  16'h0018, 1'b0, 4'd3);
    send_div_access(ModeUnused, 16'hFFFF, 1'b1, 4'd15);
    send_div_access(ModeUnused, 16'h0000, 1'b0, 4'd0);
    send_div_access(ModeRead,   16'h0000, 1'b0, 4'd0);
  endtask

  function automatic logic [CountBits-1:0] pick_cycle();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // writes followed by queries and reads close to the write cycle,
  // mixed with unrelated single accesses
  task automatic test_random_traffic(input int n_items);
    int                   sent;
    int                   burst_len;
    logic [CountBits-1:0] base;
    logic [ModeBits-1:0]  mode;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 2) == 0) begin
        base = pick_cycle();
        send_div_access(ModeWrite, base, 1'($urandom), 4'($urandom));
        burst_len = $urandom_range(1, 6);
        repeat (burst_len) begin
          base = base + 16'($urandom_range(0, 600));
          mode = ($urandom_range(0, 2) == 0) ? ModeRead : ModeQuery;
          send_div_access(mode, base, 1'($urandom), 4'($urandom));
        end
        sent += burst_len + 1;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6:     mode = ModeRead;
          7, 8, 9:                 mode = ModeWrite;
          10, 11, 12, 13, 14, 15,
          16, 17, 18:              mode = ModeQuery;
          default:                 mode = ModeUnused;
        endcase
        send_div_access(mode, pick_cycle(), 1'($urandom), 4'($urandom));
        sent++;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [CountBits-1:0] exp_val,
                             input logic [CountBits-1:0] got_val);
    if (exp_val !== got_val) begin
      $error("%s: expected 0x%04h, got 0x%04h", name, exp_val, got_val);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t got;
    result_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata);
      if (expected_div_results.size() == 0) begin
        $error("result beat with nothing expected: tdata 0x%h", m_axis_tdata);
        err_count++;
      end else begin
        exp_res = expected_div_results.pop_front();
        check_field("div_value", 16'(exp_res.div_value), 16'(got.div_value));
        check_field("old_next_increment", exp_res.old_next_increment,
                    got.old_next_increment);
        check_field("new_next_increment", exp_res.new_next_increment,
                    got.new_next_increment);
        check_field("clock_adjust", exp_res.clock_adjust, got.clock_adjust);
        check_field("offset_now", exp_res.offset_now, got.offset_now);
      end
    end
  end

  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    int drain_wait;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= ModeRead;
    s_axis_tdata  <= '0;
    cur_offset    = '0;
    last_offset   = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reads_after_reset();
    test_divider_writes();
    test_reset_queries();
    test_random_traffic(1200);
    gaps_on = 1'b0;
    test_random_traffic(580);
    s_axis_tvalid <= 1'b0;

    drain_wait = 0;
    while (expected_div_results.size() != 0 && drain_wait < 10000) begin
      @(posedge clk_i);
      drain_wait++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0 && expected_div_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (expected_div_results.size() != 0)
        $error("%0d expected results never arrived", expected_div_results.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
design/divreg_pkg.sv
design/divreg_calc.sv
design/divider_register_offset.sv
design/divreg_checker.sv
tb/divider_register_offset_tb.sv
